[sv/aes_pkg.sv]
package aes_pkg;

	// Number of cipher rounds after the initial key addition.
	localparam int ROUND_COUNT = 10;
	localparam int RND_W       = $clog2(ROUND_COUNT + 1);
	localparam int CFG_IDX_W   = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

	// Input and output payloads.
	typedef struct packed {
		logic [63:0] plain_upper;
		logic [63:0] plain_lower;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] cipher_upper;
		logic [63:0] cipher_lower;
	} aes_out_t;

	// Rijndael substitution table.
	localparam logic [7:0] SBOX [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX[x];
	endfunction

	// Multiply by two in GF(2^8) modulo x^8 + x^4 + x^3 + x + 1.
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Round constant for round rnd (1 for the first round).
	function automatic logic [7:0] rcon(input logic [RND_W-1:0] rnd);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 1; i < ROUND_COUNT; i++) begin
			if (RND_W'(i) < rnd) begin
				r = xtime(r);
			end
		end
		return r;
	endfunction

	// Byte i of a 128-bit block; byte 0 sits in the top bits.
	function automatic logic [7:0] get_byte(input logic [127:0] blk, input logic [3:0] i);
		return blk[(7'd15 - 7'(i)) * 8 +: 8];
	endfunction

endpackage

[sv/aes128_block_encrypt_unit.sv]
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       in_data   (plaintext block)
// out       output     out_valid / out_ready     out_data  (ciphertext block)
// cfg       input      cfg_valid / cfg_ready     cfg_index, cfg_data (key halves)
//
// A register follows the key addition and each round; each round stage holds
// one S-box level, MixColumns (not in the last round) and its key expansion
// step. One block enters and one leaves every cycle unless stalled. The
// round key travels down the pipeline with its block. Reset clears the key
// registers and all stage valid bits. A stage holds while its successor is
// full and stalled; empty stages fill, so bubbles close up under a stall.
module aes128_block_encrypt_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  aes_pkg::aes_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output aes_pkg::aes_out_t                    out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [aes_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [63:0]                          cfg_data
);
	import aes_pkg::*;

	logic [63:0]  key_upper_q;
	logic [63:0]  key_lower_q;

	logic         stg_vld_s   [ROUND_COUNT+1];
	logic         stg_rdy     [ROUND_COUNT+1];
	logic [127:0] stg_state_s [ROUND_COUNT+1];
	logic [127:0] stg_key_s   [ROUND_COUNT+1];
	logic [127:0] rnd_state   [ROUND_COUNT+1];
	logic [127:0] rnd_key     [ROUND_COUNT+1];

	// Key registers; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_UPPER: key_upper_q <= cfg_data;
				REG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage may load when it is empty or its content moves on.
	always_comb begin
		stg_rdy[ROUND_COUNT] = !stg_vld_s[ROUND_COUNT] || out_ready;
		for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
			stg_rdy[i] = !stg_vld_s[i] || stg_rdy[i+1];
		end
	end

	assign in_ready = stg_rdy[0];

	// Stage zero: initial key addition.
	assign rnd_key[0]   = {key_upper_q, key_lower_q};
	assign rnd_state[0] = {in_data.plain_upper, in_data.plain_lower} ^ rnd_key[0];

	// Round stages.
	for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
		aes_round u_round (
			.rnd       (RND_W'(r)),
			.state_in  (stg_state_s[r-1]),
			.key_in    (stg_key_s[r-1]),
			.state_out (rnd_state[r]),
			.key_out   (rnd_key[r])
		);
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ROUND_COUNT; i++) begin
				stg_vld_s[i] <= 1'b0;
			end
		end else begin
			if (stg_rdy[0]) begin
				stg_vld_s[0] <= in_valid;
			end
			for (int i = 1; i <= ROUND_COUNT; i++) begin
				if (stg_rdy[i]) begin
					stg_vld_s[i] <= stg_vld_s[i-1];
				end
			end
		end
	end

	// Data registers of the pipeline.
	always_ff @(posedge clk) begin
		for (int i = 0; i <= ROUND_COUNT; i++) begin
			if (stg_rdy[i]) begin
				stg_state_s[i] <= rnd_state[i];
				stg_key_s[i]   <= rnd_key[i];
			end
		end
	end

	assign out_valid             = stg_vld_s[ROUND_COUNT];
	assign out_data.cipher_upper = stg_state_s[ROUND_COUNT][127:64];
	assign out_data.cipher_lower = stg_state_s[ROUND_COUNT][63:0];

endmodule

[sv/aes_round.sv]
module aes_round (
	input  logic [aes_pkg::RND_W-1:0] rnd,
	input  logic [127:0]              state_in,
	input  logic [127:0]              key_in,
	output logic [127:0]              state_out,
	output logic [127:0]              key_out
);
	import aes_pkg::*;

	logic [7:0] sb  [16];
	logic [7:0] mc  [16];
	logic [7:0] kb  [16];
	logic [7:0] nk  [16];
	logic [7:0] tw  [4];
	logic       last;

	assign last = (rnd == RND_W'(ROUND_COUNT));

	// SubBytes with ShiftRows folded into the byte selection.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sb[i] = sbox(get_byte(state_in, 4'((5 * i) % 16)));
		end
	end

	// MixColumns, skipped in the final round.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int r = 0; r < 4; r++) begin
					mc[4*c+r] = sb[4*c+r];
				end
			end else begin
				mc[4*c+0] = xtime(sb[4*c+0]) ^ xtime(sb[4*c+1]) ^ sb[4*c+1]
					^ sb[4*c+2] ^ sb[4*c+3];
				mc[4*c+1] = sb[4*c+0] ^ xtime(sb[4*c+1]) ^ xtime(sb[4*c+2])
					^ sb[4*c+2] ^ sb[4*c+3];
				mc[4*c+2] = sb[4*c+0] ^ sb[4*c+1] ^ xtime(sb[4*c+2])
					^ xtime(sb[4*c+3]) ^ sb[4*c+3];
				mc[4*c+3] = xtime(sb[4*c+0]) ^ sb[4*c+0] ^ sb[4*c+1]
					^ sb[4*c+2] ^ xtime(sb[4*c+3]);
			end
		end
	end

	// Key expansion: rotated, substituted last word plus the round constant.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			kb[i] = get_byte(key_in, 4'(i));
		end
		tw[0] = sbox(kb[13]) ^ rcon(rnd);
		tw[1] = sbox(kb[14]);
		tw[2] = sbox(kb[15]);
		tw[3] = sbox(kb[12]);
		for (int w = 0; w < 4; w++) begin
			for (int j = 0; j < 4; j++) begin
				nk[4*w+j] = kb[4*w+j] ^ tw[j];
				tw[j]     = nk[4*w+j];
			end
		end
	end

	// AddRoundKey and repacking.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			state_out[(15 - i) * 8 +: 8] = mc[i] ^ nk[i];
			key_out[(15 - i) * 8 +: 8]   = nk[i];
		end
	end

endmodule
